>>> hdl/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types, codes and defaults of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int MAX_PARTS_DEF = 32;
    localparam int ADDR_BITS_DEF = 16;
    localparam int MAX_RESULTS   = 32;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam logic [15:0] TOTAL_RESET = 16'd1024;

    // partition kinds held in the table
    typedef enum logic [1:0] {
        PT_FREE    = 2'd0,
        PT_KERNEL  = 2'd1,
        PT_PROCESS = 2'd2
    } part_type_t;

    // request kinds
    typedef enum logic [2:0] {
        K_ALLOC_KERNEL = 3'd0,
        K_ALLOC_PROC   = 3'd1,
        K_FREE_ADDR    = 3'd2,
        K_FREE_PID     = 3'd3,
        K_COMPACT      = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_NOT_LOGGED_IN = 4'd1,
        ST_ZERO_SIZE     = 4'd2,
        ST_NO_FIT        = 4'd3,
        ST_NO_BLOCK      = 4'd4,
        ST_ALREADY_FREE  = 4'd5,
        ST_OTHER_OWNER   = 4'd6,
        ST_PROCESS_BLOCK = 4'd7,
        ST_PID_NOT_FOUND = 4'd8,
        ST_TABLE_FULL    = 4'd9
    } status_t;

    // fit policies
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // register indexes (byte address bit 2)
    localparam logic REG_FIT_POLICY   = 1'b0;
    localparam logic REG_TOTAL_MEMORY = 1'b1;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_FIT, S_FIT_DONE, S_ALLOC_WR,
        S_ADDR, S_ADDR_DONE, S_PID, S_PID_DONE,
        S_RELEASE, S_MERGE_HI, S_MERGE_LO,
        S_COMPACT, S_COMP_FIN,
        S_STATS_INIT, S_STATS, S_OUT, S_EMIT_INIT, S_EMIT
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD,
        OP_FIT_STEP, OP_ALLOC_WR,
        OP_ADDR_STEP, OP_PID_STEP,
        OP_RELEASE, OP_MERGE_HI, OP_MERGE_LO,
        OP_COMP_STEP, OP_COMP_FIN,
        OP_STATS_START, OP_STATS_STEP,
        OP_EMIT_ONE, OP_EMIT_START, OP_EMIT_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic  last_idx;
        logic  hit;
        logic  split;
        logic  full;
        logic  hit_free;
        logic  hit_owner_ok;
        logic  hit_process;
        logic  slot_free;
        logic  emit_done;
        logic  nproc_zero;
        logic  owner_zero;
        logic  size_zero;
        kind_t kind;
    } dp_stat_t;

    typedef struct packed {
        logic        we;
        logic        sel;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

>>> hdl/vpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer of the allocator: walks each request through its scan, update,
// statistics and result phases by issuing datapath operations.
// ----------------------------------------------------------------------------
module vpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vpa_pkg::dp_stat_t  st,
    output vpa_pkg::dp_cmd_t   cmd
);

    vpa_pkg::state_t  state_reg, state_next;
    vpa_pkg::status_t code_reg, code_next;

    // state and result code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vpa_pkg::S_IDLE;
            code_reg  <= vpa_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = vpa_pkg::OP_NONE;
        cmd.code   = code_reg;
        s_tready   = 1'b0;
        case (state_reg)
            vpa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = vpa_pkg::OP_LOAD;
                    code_next  = vpa_pkg::ST_OK;
                    state_next = vpa_pkg::S_DISPATCH;
                end
            end
            vpa_pkg::S_DISPATCH:
            begin
                case (st.kind)
                    vpa_pkg::K_ALLOC_KERNEL, vpa_pkg::K_ALLOC_PROC:
                    begin
                        if (st.owner_zero)
                        begin
                            code_next  = vpa_pkg::ST_NOT_LOGGED_IN;
                            state_next = vpa_pkg::S_STATS_INIT;
                        end
                        else if (st.size_zero)
                        begin
                            code_next  = vpa_pkg::ST_ZERO_SIZE;
                            state_next = vpa_pkg::S_STATS_INIT;
                        end
                        else
                        begin
                            state_next = vpa_pkg::S_FIT;
                        end
                    end
                    vpa_pkg::K_FREE_ADDR: state_next = vpa_pkg::S_ADDR;
                    vpa_pkg::K_FREE_PID:  state_next = vpa_pkg::S_PID;
                    vpa_pkg::K_COMPACT:   state_next = vpa_pkg::S_COMPACT;
                    default:              state_next = vpa_pkg::S_IDLE;
                endcase
            end
            vpa_pkg::S_FIT:
            begin
                cmd.op = vpa_pkg::OP_FIT_STEP;
                if (st.last_idx)
                begin
                    state_next = vpa_pkg::S_FIT_DONE;
                end
            end
            vpa_pkg::S_FIT_DONE:
            begin
                state_next = vpa_pkg::S_STATS_INIT;
                if (!st.hit)
                begin
                    code_next = vpa_pkg::ST_NO_FIT;
                end
                else if (st.split && st.full)
                begin
                    code_next = vpa_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    state_next = vpa_pkg::S_ALLOC_WR;
                end
            end
            vpa_pkg::S_ALLOC_WR:
            begin
                cmd.op     = vpa_pkg::OP_ALLOC_WR;
                state_next = vpa_pkg::S_STATS_INIT;
            end
            vpa_pkg::S_ADDR:
            begin
                cmd.op = vpa_pkg::OP_ADDR_STEP;
                if (st.last_idx)
                begin
                    state_next = vpa_pkg::S_ADDR_DONE;
                end
            end
            vpa_pkg::S_ADDR_DONE:
            begin
                state_next = vpa_pkg::S_STATS_INIT;
                if (!st.hit)
                begin
                    code_next = vpa_pkg::ST_NO_BLOCK;
                end
                else if (st.hit_free)
                begin
                    code_next = vpa_pkg::ST_ALREADY_FREE;
                end
                else if (!st.hit_owner_ok)
                begin
                    code_next = vpa_pkg::ST_OTHER_OWNER;
                end
                else if (st.hit_process)
                begin
                    code_next = vpa_pkg::ST_PROCESS_BLOCK;
                end
                else
                begin
                    state_next = vpa_pkg::S_RELEASE;
                end
            end
            vpa_pkg::S_PID:
            begin
                cmd.op = vpa_pkg::OP_PID_STEP;
                if (st.last_idx)
                begin
                    state_next = vpa_pkg::S_PID_DONE;
                end
            end
            vpa_pkg::S_PID_DONE:
            begin
                if (!st.hit)
                begin
                    code_next  = vpa_pkg::ST_PID_NOT_FOUND;
                    state_next = vpa_pkg::S_STATS_INIT;
                end
                else
                begin
                    state_next = vpa_pkg::S_RELEASE;
                end
            end
            vpa_pkg::S_RELEASE:
            begin
                cmd.op     = vpa_pkg::OP_RELEASE;
                state_next = vpa_pkg::S_MERGE_HI;
            end
            vpa_pkg::S_MERGE_HI:
            begin
                cmd.op     = vpa_pkg::OP_MERGE_HI;
                state_next = vpa_pkg::S_MERGE_LO;
            end
            vpa_pkg::S_MERGE_LO:
            begin
                cmd.op     = vpa_pkg::OP_MERGE_LO;
                state_next = vpa_pkg::S_STATS_INIT;
            end
            vpa_pkg::S_COMPACT:
            begin
                cmd.op = vpa_pkg::OP_COMP_STEP;
                if (st.last_idx)
                begin
                    state_next = vpa_pkg::S_COMP_FIN;
                end
            end
            vpa_pkg::S_COMP_FIN:
            begin
                cmd.op     = vpa_pkg::OP_COMP_FIN;
                state_next = vpa_pkg::S_STATS_INIT;
            end
            vpa_pkg::S_STATS_INIT:
            begin
                cmd.op     = vpa_pkg::OP_STATS_START;
                state_next = vpa_pkg::S_STATS;
            end
            vpa_pkg::S_STATS:
            begin
                cmd.op = vpa_pkg::OP_STATS_STEP;
                if (st.last_idx)
                begin
                    if (st.kind == vpa_pkg::K_COMPACT && !st.nproc_zero)
                    begin
                        state_next = vpa_pkg::S_EMIT_INIT;
                    end
                    else
                    begin
                        state_next = vpa_pkg::S_OUT;
                    end
                end
            end
            vpa_pkg::S_OUT:
            begin
                if (st.slot_free)
                begin
                    cmd.op     = vpa_pkg::OP_EMIT_ONE;
                    state_next = vpa_pkg::S_IDLE;
                end
            end
            vpa_pkg::S_EMIT_INIT:
            begin
                cmd.op     = vpa_pkg::OP_EMIT_START;
                state_next = vpa_pkg::S_EMIT;
            end
            vpa_pkg::S_EMIT:
            begin
                if (st.emit_done)
                begin
                    state_next = vpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op = vpa_pkg::OP_EMIT_STEP;
                end
            end
            default:
            begin
                state_next = vpa_pkg::S_IDLE;
            end
        endcase
    end

    // a request is taken only from idle
    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == vpa_pkg::OP_LOAD |-> state_reg == vpa_pkg::S_IDLE)
        else $error("request loaded outside idle");

    // a single result is only issued into a free output slot
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == vpa_pkg::OP_EMIT_ONE |-> st.slot_free)
        else $error("result issued into a busy output slot");

    // the sequencer never stays in the dispatch state
    a_dispatch_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vpa_pkg::S_DISPATCH |=> state_reg != vpa_pkg::S_DISPATCH)
        else $error("dispatch held for more than one cycle");

endmodule

>>> hdl/vpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_dp
// Datapath of the allocator: partition table, scan pointer, fit and match
// search, split, release and merge, compaction, statistics and result stage.
// ----------------------------------------------------------------------------
module vpa_dp
#(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF,
    parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  vpa_pkg::dp_cmd_t   cmd,
    output vpa_pkg::dp_stat_t  st,
    input  vpa_pkg::cfg_wr_t   cfg,
    output logic [1:0]         fit_policy,
    output logic [15:0]        total_memory,
    input  logic [2:0]         in_kind,
    input  logic [55:0]        in_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [103:0]       m_tdata,
    output logic               m_tlast
);

    localparam int W  = ADDR_BITS;
    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int RW = vpa_pkg::RES_CNT_W;
    localparam int AW = (W > 16) ? W : 16;

    // partition table
    logic [W-1:0]          start_reg [MAX_PARTS];
    logic [W-1:0]          start_next[MAX_PARTS];
    logic [W-1:0]          size_reg  [MAX_PARTS];
    logic [W-1:0]          size_next [MAX_PARTS];
    vpa_pkg::part_type_t   type_reg  [MAX_PARTS];
    vpa_pkg::part_type_t   type_next [MAX_PARTS];
    logic [15:0]           pid_reg   [MAX_PARTS];
    logic [15:0]           pid_next  [MAX_PARTS];
    logic [7:0]            owner_reg [MAX_PARTS];
    logic [7:0]            owner_next[MAX_PARTS];
    logic [CW-1:0]         count_reg, count_next;

    // request and working registers
    logic [2:0]            kind_reg,  kind_next;
    logic [7:0]            rowner_reg, rowner_next;
    logic [15:0]           rpid_reg,  rpid_next;
    logic [W-1:0]          rsize_reg, rsize_next;
    logic [15:0]           raddr_reg, raddr_next;
    logic [CW-1:0]         ptr_reg,   ptr_next;
    logic [IW-1:0]         idx_reg,   idx_next;
    logic                  hit_reg,   hit_next;
    logic [W-1:0]          cand_reg,  cand_next;
    logic [W-1:0]          rstart_reg, rstart_next;
    logic [W-1:0]          rrel_reg,  rrel_next;
    logic [CW-1:0]         w_reg,     w_next;
    logic [W-1:0]          cursor_reg, cursor_next;
    logic [RW-1:0]         nproc_reg, nproc_next;
    logic [RW-1:0]         emitted_reg, emitted_next;
    logic [15:0]           used_reg,  used_next;
    logic [15:0]           free_reg,  free_next;
    logic [W-1:0]          large_reg, large_next;
    logic [1:0]            fit_reg,   fit_next;
    logic [15:0]           total_reg, total_next;

    // result stage
    logic                  ovalid_reg, ovalid_next;
    logic [103:0]          odata_reg,  odata_next;
    logic                  olast_reg,  olast_next;

    // entry reads
    logic [IW-1:0]         ptr_ix, ip_ix, im_ix, w_ix;
    logic [W-1:0]          e_start, e_size;
    vpa_pkg::part_type_t   e_type;
    logic [15:0]           e_pid;
    logic [7:0]            e_owner;
    logic                  slot_free;
    logic [W-1:0]          total_m;

    assign ptr_ix  = ptr_reg[IW-1:0];
    assign ip_ix   = idx_reg + IW'(1);
    assign im_ix   = idx_reg - IW'(1);
    assign w_ix    = w_reg[IW-1:0];
    assign e_start = start_reg[ptr_ix];
    assign e_size  = size_reg[ptr_ix];
    assign e_type  = type_reg[ptr_ix];
    assign e_pid   = pid_reg[ptr_ix];
    assign e_owner = owner_reg[ptr_ix];
    assign total_m = W'(total_reg);
    assign slot_free = !ovalid_reg || m_tready;

    // status towards the controller
    always_comb
    begin
        st.last_idx     = (ptr_reg == count_reg - CW'(1));
        st.hit          = hit_reg;
        st.split        = (cand_reg != rsize_reg);
        st.full         = (count_reg >= CW'(MAX_PARTS));
        st.hit_free     = (type_reg[idx_reg] == vpa_pkg::PT_FREE);
        st.hit_owner_ok = (owner_reg[idx_reg] == rowner_reg);
        st.hit_process  = (type_reg[idx_reg] == vpa_pkg::PT_PROCESS);
        st.slot_free    = slot_free;
        st.emit_done    = (emitted_reg == nproc_reg);
        st.nproc_zero   = (nproc_reg == '0);
        st.owner_zero   = (rowner_reg == 8'd0);
        st.size_zero    = (rsize_reg == '0);
        st.kind         = vpa_pkg::kind_t'(kind_reg);
    end

    assign fit_policy   = fit_reg;
    assign total_memory = total_reg;
    assign m_tvalid     = ovalid_reg;
    assign m_tdata      = odata_reg;
    assign m_tlast      = olast_reg;

    // table and working register updates
    always_comb
    begin
        logic          take;
        logic          lo_ok;
        logic          hi_ok;
        logic [CW-1:0] wn;

        start_next  = start_reg;
        size_next   = size_reg;
        type_next   = type_reg;
        pid_next    = pid_reg;
        owner_next  = owner_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        rowner_next = rowner_reg;
        rpid_next   = rpid_reg;
        rsize_next  = rsize_reg;
        raddr_next  = raddr_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        cand_next   = cand_reg;
        rstart_next = rstart_reg;
        rrel_next   = rrel_reg;
        w_next      = w_reg;
        cursor_next = cursor_reg;
        nproc_next  = nproc_reg;
        emitted_next = emitted_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        large_next  = large_reg;
        fit_next    = fit_reg;
        total_next  = total_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        take        = 1'b0;
        lo_ok       = 1'b0;
        hi_ok       = 1'b0;
        wn          = w_reg;

        // drop a result once taken
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (cmd.op)
            vpa_pkg::OP_LOAD:
            begin
                kind_next   = in_kind;
                rowner_next = in_data[7:0];
                rpid_next   = in_data[23:8];
                rsize_next  = W'(in_data[39:24]);
                raddr_next  = in_data[55:40];
                ptr_next    = '0;
                hit_next    = 1'b0;
                idx_next    = '0;
                cand_next   = '0;
                rstart_next = '0;
                rrel_next   = '0;
                w_next      = '0;
                cursor_next = '0;
                nproc_next  = '0;
                emitted_next = '0;
            end
            vpa_pkg::OP_FIT_STEP:
            begin
                // keep the first, smallest or largest free block that fits
                if (e_type == vpa_pkg::PT_FREE && e_size >= rsize_reg)
                begin
                    if (!hit_reg)
                    begin
                        take = 1'b1;
                    end
                    else if (fit_reg == vpa_pkg::FIT_BEST && e_size < cand_reg)
                    begin
                        take = 1'b1;
                    end
                    else if (fit_reg == vpa_pkg::FIT_WORST && e_size > cand_reg)
                    begin
                        take = 1'b1;
                    end
                end
                if (take)
                begin
                    hit_next  = 1'b1;
                    idx_next  = ptr_ix;
                    cand_next = e_size;
                end
                ptr_next = ptr_reg + CW'(1);
            end
            vpa_pkg::OP_ALLOC_WR:
            begin
                // split: open a slot above the chosen block for the remainder
                if (cand_reg != rsize_reg)
                begin
                    for (int j = 1; j < MAX_PARTS; j++)
                    begin
                        if (IW'(j) > idx_reg)
                        begin
                            start_next[j] = start_reg[j-1];
                            size_next[j]  = size_reg[j-1];
                            type_next[j]  = type_reg[j-1];
                            pid_next[j]   = pid_reg[j-1];
                            owner_next[j] = owner_reg[j-1];
                        end
                    end
                    start_next[ip_ix] = start_reg[idx_reg] + rsize_reg;
                    size_next[ip_ix]  = cand_reg - rsize_reg;
                    type_next[ip_ix]  = vpa_pkg::PT_FREE;
                    pid_next[ip_ix]   = 16'd0;
                    owner_next[ip_ix] = 8'd0;
                    count_next = count_reg + CW'(1);
                end
                size_next[idx_reg]  = rsize_reg;
                owner_next[idx_reg] = rowner_reg;
                if (kind_reg == vpa_pkg::K_ALLOC_PROC)
                begin
                    type_next[idx_reg] = vpa_pkg::PT_PROCESS;
                    pid_next[idx_reg]  = rpid_reg;
                end
                else
                begin
                    type_next[idx_reg] = vpa_pkg::PT_KERNEL;
                    pid_next[idx_reg]  = 16'd0;
                end
                rstart_next = start_reg[idx_reg];
            end
            vpa_pkg::OP_ADDR_STEP:
            begin
                if (!hit_reg && AW'(e_start) == AW'(raddr_reg))
                begin
                    hit_next = 1'b1;
                    idx_next = ptr_ix;
                end
                ptr_next = ptr_reg + CW'(1);
            end
            vpa_pkg::OP_PID_STEP:
            begin
                if (!hit_reg && e_type == vpa_pkg::PT_PROCESS &&
                    e_owner == rowner_reg && e_pid == rpid_reg)
                begin
                    hit_next = 1'b1;
                    idx_next = ptr_ix;
                end
                ptr_next = ptr_reg + CW'(1);
            end
            vpa_pkg::OP_RELEASE:
            begin
                type_next[idx_reg]  = vpa_pkg::PT_FREE;
                pid_next[idx_reg]   = 16'd0;
                owner_next[idx_reg] = 8'd0;
                rstart_next = start_reg[idx_reg];
                rrel_next   = size_reg[idx_reg];
            end
            vpa_pkg::OP_MERGE_HI:
            begin
                // absorb the free neighbour above and close the gap
                hi_ok = (CW'(idx_reg) + CW'(1) < count_reg) &&
                        (type_reg[ip_ix] == vpa_pkg::PT_FREE) &&
                        (start_reg[idx_reg] + size_reg[idx_reg] == start_reg[ip_ix]);
                if (hi_ok)
                begin
                    size_next[idx_reg] = size_reg[idx_reg] + size_reg[ip_ix];
                    for (int j = 0; j < MAX_PARTS - 1; j++)
                    begin
                        if (IW'(j) > idx_reg)
                        begin
                            start_next[j] = start_reg[j+1];
                            size_next[j]  = size_reg[j+1];
                            type_next[j]  = type_reg[j+1];
                            pid_next[j]   = pid_reg[j+1];
                            owner_next[j] = owner_reg[j+1];
                        end
                    end
                    start_next[MAX_PARTS-1] = '0;
                    size_next[MAX_PARTS-1]  = '0;
                    type_next[MAX_PARTS-1]  = vpa_pkg::PT_FREE;
                    pid_next[MAX_PARTS-1]   = 16'd0;
                    owner_next[MAX_PARTS-1] = 8'd0;
                    count_next = count_reg - CW'(1);
                end
            end
            vpa_pkg::OP_MERGE_LO:
            begin
                // fold the block into the free neighbour below
                lo_ok = (idx_reg != '0) &&
                        (type_reg[im_ix] == vpa_pkg::PT_FREE) &&
                        (start_reg[im_ix] + size_reg[im_ix] == start_reg[idx_reg]);
                if (lo_ok)
                begin
                    size_next[im_ix] = size_reg[im_ix] + size_reg[idx_reg];
                    for (int j = 0; j < MAX_PARTS - 1; j++)
                    begin
                        if (IW'(j) >= idx_reg)
                        begin
                            start_next[j] = start_reg[j+1];
                            size_next[j]  = size_reg[j+1];
                            type_next[j]  = type_reg[j+1];
                            pid_next[j]   = pid_reg[j+1];
                            owner_next[j] = owner_reg[j+1];
                        end
                    end
                    start_next[MAX_PARTS-1] = '0;
                    size_next[MAX_PARTS-1]  = '0;
                    type_next[MAX_PARTS-1]  = vpa_pkg::PT_FREE;
                    pid_next[MAX_PARTS-1]   = 16'd0;
                    owner_next[MAX_PARTS-1] = 8'd0;
                    count_next = count_reg - CW'(1);
                end
            end
            vpa_pkg::OP_COMP_STEP:
            begin
                // move an allocated block down to the cursor
                if (e_type != vpa_pkg::PT_FREE)
                begin
                    start_next[w_ix] = cursor_reg;
                    size_next[w_ix]  = e_size;
                    type_next[w_ix]  = e_type;
                    pid_next[w_ix]   = e_pid;
                    owner_next[w_ix] = e_owner;
                    cursor_next = cursor_reg + e_size;
                    w_next      = w_reg + CW'(1);
                    if (e_type == vpa_pkg::PT_PROCESS &&
                        nproc_reg < RW'(vpa_pkg::MAX_RESULTS))
                    begin
                        nproc_next = nproc_reg + RW'(1);
                    end
                end
                ptr_next = ptr_reg + CW'(1);
            end
            vpa_pkg::OP_COMP_FIN:
            begin
                // clear the rest and append one free tail when memory is left and a slot is free
                for (int j = 0; j < MAX_PARTS; j++)
                begin
                    if (CW'(j) >= w_reg)
                    begin
                        start_next[j] = '0;
                        size_next[j]  = '0;
                        type_next[j]  = vpa_pkg::PT_FREE;
                        pid_next[j]   = 16'd0;
                        owner_next[j] = 8'd0;
                    end
                end
                if (cursor_reg < total_m && w_reg < CW'(MAX_PARTS))
                begin
                    start_next[w_ix] = cursor_reg;
                    size_next[w_ix]  = total_m - cursor_reg;
                    wn = w_reg + CW'(1);
                end
                count_next = (wn == '0) ? CW'(1) : wn;
            end
            vpa_pkg::OP_STATS_START:
            begin
                ptr_next   = '0;
                used_next  = 16'd0;
                free_next  = 16'd0;
                large_next = '0;
            end
            vpa_pkg::OP_STATS_STEP:
            begin
                if (e_type == vpa_pkg::PT_FREE)
                begin
                    free_next = free_reg + 16'(e_size);
                    if (e_size > large_reg)
                    begin
                        large_next = e_size;
                    end
                end
                else
                begin
                    used_next = used_reg + 16'(e_size);
                end
                ptr_next = ptr_reg + CW'(1);
            end
            vpa_pkg::OP_EMIT_ONE:
            begin
                ovalid_next = 1'b1;
                olast_next  = 1'b1;
                odata_next  = {4'd0, 16'(large_reg), free_reg, used_reg, 16'd0,
                               16'(rrel_reg), 16'(rstart_reg), cmd.code};
            end
            vpa_pkg::OP_EMIT_START:
            begin
                ptr_next = '0;
            end
            vpa_pkg::OP_EMIT_STEP:
            begin
                // report process blocks in address order; hold while the slot is busy
                if (e_type == vpa_pkg::PT_PROCESS)
                begin
                    if (slot_free)
                    begin
                        ovalid_next  = 1'b1;
                        olast_next   = (emitted_reg + RW'(1) == nproc_reg);
                        odata_next   = {4'd0, 16'(large_reg), free_reg, used_reg, e_pid,
                                        16'd0, 16'(e_start), vpa_pkg::ST_OK};
                        emitted_next = emitted_reg + RW'(1);
                        ptr_next     = ptr_reg + CW'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase

        // register writes; a new total reinitialises the table
        if (cfg.we)
        begin
            if (cfg.sel == vpa_pkg::REG_FIT_POLICY)
            begin
                fit_next = cfg.data[1:0];
            end
            else
            begin
                total_next = cfg.data;
                for (int j = 0; j < MAX_PARTS; j++)
                begin
                    start_next[j] = '0;
                    size_next[j]  = '0;
                    type_next[j]  = vpa_pkg::PT_FREE;
                    pid_next[j]   = 16'd0;
                    owner_next[j] = 8'd0;
                end
                size_next[0] = W'(cfg.data);
                count_next   = CW'(1);
            end
        end
    end

    // control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PARTS; j++)
            begin
                start_reg[j] <= '0;
                size_reg[j]  <= '0;
                type_reg[j]  <= vpa_pkg::PT_FREE;
            end
            size_reg[0] <= W'(vpa_pkg::TOTAL_RESET);
            count_reg   <= CW'(1);
            fit_reg     <= 2'd0;
            total_reg   <= vpa_pkg::TOTAL_RESET;
            ovalid_reg  <= 1'b0;
            ptr_reg     <= '0;
            hit_reg     <= 1'b0;
            w_reg       <= '0;
            nproc_reg   <= '0;
            emitted_reg <= '0;
            kind_reg    <= '0;
        end
        else
        begin
            start_reg   <= start_next;
            size_reg    <= size_next;
            type_reg    <= type_next;
            count_reg   <= count_next;
            fit_reg     <= fit_next;
            total_reg   <= total_next;
            ovalid_reg  <= ovalid_next;
            ptr_reg     <= ptr_next;
            hit_reg     <= hit_next;
            w_reg       <= w_next;
            nproc_reg   <= nproc_next;
            emitted_reg <= emitted_next;
            kind_reg    <= kind_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pid_reg    <= pid_next;
        owner_reg  <= owner_next;
        rowner_reg <= rowner_next;
        rpid_reg   <= rpid_next;
        rsize_reg  <= rsize_next;
        raddr_reg  <= raddr_next;
        idx_reg    <= idx_next;
        cand_reg   <= cand_next;
        rstart_reg <= rstart_next;
        rrel_reg   <= rrel_next;
        cursor_reg <= cursor_next;
        used_reg   <= used_next;
        free_reg   <= free_next;
        large_reg  <= large_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
    end

    // the table never goes empty nor beyond its depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CW'(MAX_PARTS))
        else $error("partition count out of range");

    // a split adds exactly one partition
    a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == vpa_pkg::OP_ALLOC_WR && cand_reg != rsize_reg && !cfg.we
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("split did not add one partition");

    // compaction never reports more blocks than it moved
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= nproc_reg)
        else $error("more compaction results than process blocks");

endmodule

>>> hdl/variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Address-ordered partition table with first/best/worst fit allocation,
// free by address or pid with coalescing, and compaction.
// ----------------------------------------------------------------------------
//  channel   dir  group                     contents
//  request   in   s_tvalid/s_tready/tdata   tuser kind, tdata owner/pid/size/address
//  result    out  m_tvalid/m_tready/tdata   tdata status..largest, tlast final
//  config    in   psel/penable/pwrite/...   fit_policy @0x0, total_memory @0x4
//
//  The table is walked one entry per cycle for the search, the compaction move,
//  the totals and the compaction report; the report walk holds while the
//  result output is stalled.
//  Reset leaves one free partition of 1024 KB; writing total_memory rebuilds it.
//  A stalled result output holds the sequencer only while results are issued.
// ----------------------------------------------------------------------------
module variable_partition_allocator
#(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF,
    parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    // request
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // owner_id[7:0], pid[23:8], size_kb[39:24], address[55:40]
    input  logic [2:0]    s_tuser,   // kind[2:0]
    // result
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // status[3:0], start_addr[19:4], released_kb[35:20],
                                     // moved_pid[51:36], used_kb[67:52], free_kb[83:68],
                                     // largest_free_kb[99:84], zero fill
    output logic          m_tlast,   // last
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    vpa_pkg::dp_cmd_t  cmd;
    vpa_pkg::dp_stat_t st;
    vpa_pkg::cfg_wr_t  cfg;
    logic [1:0]        fit_policy;
    logic [15:0]       total_memory;

    // decode register writes and reads
    assign pready = 1'b1;
    assign cfg    = {psel && penable && pwrite, paddr[2], pwdata[15:0]};

    always_comb
    begin
        case (paddr[2])
            vpa_pkg::REG_FIT_POLICY:   prdata = {30'd0, fit_policy};
            vpa_pkg::REG_TOTAL_MEMORY: prdata = {16'd0, total_memory};
            default:                   prdata = 32'd0;
        endcase
    end

    vpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vpa_dp
    #(
        .MAX_PARTS (MAX_PARTS),
        .ADDR_BITS (ADDR_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg          (cfg),
        .fit_policy   (fit_policy),
        .total_memory (total_memory),
        .in_kind      (s_tuser),
        .in_data      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
